// ===== hw/rtl/tsp_pkg.sv =====
package tsp_pkg;

    localparam int FUNC_W   = 2;
    localparam int DELAY_W  = 32;
    localparam int TAG_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int TIME_W   = 48;
    localparam int KIND_W   = 3;

    // a tick reports at most this many fired slots
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SCHEDULED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POOL_FULL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CANCEL_IGN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IDLE       = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              freed;
        logic              last;
    } t_result;

    typedef struct packed {
        logic               used;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] period;
        logic [TIME_W-1:0]  ring;
    } t_slot;

endpackage

// ===== hw/rtl/tsp_in_if.sv =====
interface tsp_in_if;
    logic                         valid;
    logic                         ready;
    logic [tsp_pkg::FUNC_W-1:0]   func;
    logic [tsp_pkg::DELAY_W-1:0]  delay_ms;
    logic                         repeat_req;
    logic [tsp_pkg::TAG_W-1:0]    target_tag;
    logic [tsp_pkg::SLOT_W-1:0]   slot_in;
    logic [tsp_pkg::TIME_W-1:0]   now_ms;

    modport source (
        output valid, func, delay_ms, repeat_req, target_tag, slot_in, now_ms,
        input  ready
    );
    modport sink (
        input  valid, func, delay_ms, repeat_req, target_tag, slot_in, now_ms,
        output ready
    );
endinterface

// ===== hw/rtl/tsp_out_if.sv =====
interface tsp_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsp_pkg::KIND_W-1:0]  kind;
    logic [tsp_pkg::SLOT_W-1:0]  slot_out;
    logic [tsp_pkg::TAG_W-1:0]   tag_out;
    logic                        freed;
    logic                        last;

    modport source (
        output valid, kind, slot_out, tag_out, freed, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot_out, tag_out, freed, last,
        output ready
    );
endinterface

// ===== hw/rtl/timer_slot_pool_unit.sv =====
// Timer slot pool, one slot record read per cycle while no result stalls, from a single-port-read memory.
// Schedule: the scan stops at the lowest free slot.
// Any item also waits while a result stalls.
// One item at a time; the input is ready only between items.
// Reset (synchronous, active low) starts a clearing pass that frees every slot;
// no item is taken until it ends.
module timer_slot_pool_unit #(
    parameter int SLOTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsp_in_if.sink       i_in,
    tsp_out_if.source    o_out
);
    import tsp_pkg::*;

    localparam int IDXW = $clog2(SLOTS);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCHED  = 6'b000100,
        ST_CANCEL = 6'b001000,
        ST_TICK   = 6'b010000,
        ST_FLUSH  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    t_slot mem [SLOTS];

    // latched item
    logic [TIME_W-1:0]  r_now;
    logic [DELAY_W-1:0] r_delay;
    logic [DELAY_W-1:0] r_period;
    logic [TAG_W-1:0]   r_tag;
    logic [SLOT_W-1:0]  r_slot_in;

    // scan pipeline: issue stage and evaluate stage
    logic [IDXW-1:0]    r_rd_idx;
    logic               r_issue_on;
    logic               r_ev_valid;
    logic [IDXW-1:0]    r_ev_idx;
    t_slot              r_rd_data;

    // one fire word held back so the last one of a tick can be marked
    logic               r_hold_valid;
    t_result            r_hold;
    logic [CNT_W-1:0]   r_fire_cnt;

    logic               r_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               emit_req;
    t_result            emit_res;
    logic               stall;
    logic               finish;
    logic               wr_req;
    t_slot              wr_req_data;
    logic               hold_load;
    t_result            hold_res;
    logic               rd_en;
    logic               wr_en;
    logic [IDXW-1:0]    wr_idx;
    t_slot              wr_data;
    logic               accept;
    logic               scan_state;
    logic               ev_last_idx;
    logic               in_range;

    logic [TIME_W-1:0]  alu_base;
    logic [DELAY_W-1:0] alu_incr;
    logic [TIME_W-1:0]  alu_sum;
    logic               alu_due;

    assign alu_base = (r_state == ST_SCHED) ? r_now : r_rd_data.ring;
    assign alu_incr = (r_state == ST_SCHED) ? r_delay : r_rd_data.period;

    tsp_alu u_alu (
        .i_base (alu_base),
        .i_incr (alu_incr),
        .i_ring (r_rd_data.ring),
        .i_now  (r_now),
        .o_sum  (alu_sum),
        .o_due  (alu_due)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign scan_state  = (r_state == ST_SCHED) || (r_state == ST_CANCEL)
                         || (r_state == ST_TICK);
    assign ev_last_idx = (r_ev_idx == IDXW'(SLOTS - 1));
    assign in_range    = (32'(r_slot_in) < 32'(SLOTS));

    always_comb begin
        emit_req    = 1'b0;
        emit_res    = '0;
        finish      = 1'b0;
        wr_req      = 1'b0;
        wr_req_data = r_rd_data;
        hold_load   = 1'b0;
        hold_res    = '0;
        n_state     = r_state;

        unique case (r_state)
            ST_SCHED: begin
                if (r_ev_valid) begin
                    if (!r_rd_data.used) begin
                        wr_req             = 1'b1;
                        wr_req_data.used   = 1'b1;
                        wr_req_data.tag    = r_tag;
                        wr_req_data.period = r_period;
                        wr_req_data.ring   = alu_sum;
                        emit_req           = 1'b1;
                        emit_res.kind      = KIND_SCHEDULED;
                        emit_res.slot      = SLOT_W'(r_ev_idx);
                        emit_res.last      = 1'b1;
                        finish             = 1'b1;
                    end else if (ev_last_idx) begin
                        emit_req      = 1'b1;
                        emit_res.kind = KIND_POOL_FULL;
                        emit_res.last = 1'b1;
                        finish        = 1'b1;
                    end
                end
                if (finish && (!emit_req || out_free)) n_state = ST_IDLE;
            end
            ST_CANCEL: begin
                if (r_ev_valid) begin
                    emit_req      = 1'b1;
                    emit_res.slot = r_slot_in;
                    emit_res.last = 1'b1;
                    finish        = 1'b1;
                    if (in_range && r_rd_data.used) begin
                        wr_req           = 1'b1;
                        wr_req_data.used = 1'b0;
                        emit_res.kind    = KIND_CANCELLED;
                    end else begin
                        emit_res.kind = KIND_CANCEL_IGN;
                    end
                end
                if (finish && (!emit_req || out_free)) n_state = ST_IDLE;
            end
            ST_TICK: begin
                if (r_ev_valid) begin
                    if (r_fire_cnt == CNT_W'(MAX_RESULTS)) begin
                        finish = 1'b1;
                    end else begin
                        if (r_rd_data.used && alu_due) begin
                            wr_req = 1'b1;
                            if (r_rd_data.period != '0) begin
                                wr_req_data.ring = alu_sum;
                            end else begin
                                wr_req_data.used = 1'b0;
                            end
                            hold_load      = 1'b1;
                            hold_res.kind  = KIND_FIRED;
                            hold_res.slot  = SLOT_W'(r_ev_idx);
                            hold_res.tag   = r_rd_data.tag;
                            hold_res.freed = (r_rd_data.period == '0);
                            hold_res.last  = 1'b0;
                            // previous fire goes out now, not the last one
                            if (r_hold_valid) begin
                                emit_req = 1'b1;
                                emit_res = r_hold;
                            end
                        end
                        if (ev_last_idx) finish = 1'b1;
                    end
                end
                if (finish && (!emit_req || out_free)) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                emit_req      = 1'b1;
                emit_res.last = 1'b1;
                if (r_hold_valid) begin
                    emit_res.kind  = KIND_FIRED;
                    emit_res.slot  = r_hold.slot;
                    emit_res.tag   = r_hold.tag;
                    emit_res.freed = r_hold.freed;
                end else begin
                    emit_res.kind = KIND_IDLE;
                end
                if (out_free) n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (r_rd_idx == IDXW'(SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_in.func)
                        FUNC_SCHEDULE: n_state = ST_SCHED;
                        FUNC_CANCEL:   n_state = ST_CANCEL;
                        FUNC_TICK:     n_state = ST_TICK;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign stall   = emit_req && !out_free;
    assign rd_en   = scan_state && r_issue_on && !stall && !finish;
    assign wr_en   = (r_state == ST_CLEAR) || (wr_req && !stall);
    assign wr_idx  = (r_state == ST_CLEAR) ? r_rd_idx : r_ev_idx;
    assign wr_data = (r_state == ST_CLEAR) ? t_slot'('0) : wr_req_data;

    // slot record store
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_idx] <= wr_data;
        if (rd_en) r_rd_data <= mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_rd_idx     <= '0;
            r_issue_on   <= 1'b0;
            r_ev_valid   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_fire_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_CLEAR) begin
                r_rd_idx <= r_rd_idx + IDXW'(1);
            end else if (accept) begin
                r_rd_idx     <= (i_in.func == FUNC_CANCEL) ? IDXW'(i_in.slot_in) : '0;
                r_issue_on   <= 1'b1;
                r_ev_valid   <= 1'b0;
                r_hold_valid <= 1'b0;
                r_fire_cnt   <= '0;
            end else if (!stall) begin
                r_ev_valid <= rd_en;
                if (finish) r_issue_on <= 1'b0;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + IDXW'(1);
                    if ((r_state == ST_CANCEL) || (r_rd_idx == IDXW'(SLOTS - 1)))
                        r_issue_on <= 1'b0;
                end
                if (hold_load) begin
                    r_hold_valid <= 1'b1;
                    r_fire_cnt   <= r_fire_cnt + CNT_W'(1);
                end
            end

            if (emit_req && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now     <= i_in.now_ms;
            r_delay   <= (i_in.delay_ms == '0) ? DELAY_W'(1) : i_in.delay_ms;
            r_period  <= !i_in.repeat_req ? '0 :
                         ((i_in.delay_ms == '0) ? DELAY_W'(1) : i_in.delay_ms);
            r_tag     <= i_in.target_tag;
            r_slot_in <= i_in.slot_in;
        end
        if (rd_en) r_ev_idx <= r_rd_idx;
        if (hold_load && !stall) r_hold <= hold_res;
        if (emit_req && out_free) r_out <= emit_res;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out.kind;
    assign o_out.slot_out = r_out.slot;
    assign o_out.tag_out  = r_out.tag;
    assign o_out.freed    = r_out.freed;
    assign o_out.last     = r_out.last;
endmodule

// ===== hw/rtl/tsp_alu.sv =====
// Shared time unit: saturating 48 + 32 bit add and the due compare.
module tsp_alu (
    input  logic [tsp_pkg::TIME_W-1:0]  i_base,
    input  logic [tsp_pkg::DELAY_W-1:0] i_incr,
    input  logic [tsp_pkg::TIME_W-1:0]  i_ring,
    input  logic [tsp_pkg::TIME_W-1:0]  i_now,
    output logic [tsp_pkg::TIME_W-1:0]  o_sum,
    output logic                        o_due
);
    import tsp_pkg::*;

    logic [TIME_W:0] sum_full;

    assign sum_full = {1'b0, i_base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, i_incr};
    assign o_sum    = sum_full[TIME_W] ? {TIME_W{1'b1}} : sum_full[TIME_W-1:0];
    assign o_due    = (i_ring <= i_now);
endmodule
